// ----- rtl/hae_pkg.sv -----
package hae_pkg;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [3:0] {
    PH_OUT    = 4'd0,
    PH_LT     = 4'd1,
    PH_LTA    = 4'd2,
    PH_GAP    = 4'd3,
    PH_SKIP   = 4'd4,
    PH_H1     = 4'd5,
    PH_H2     = 4'd6,
    PH_H3     = 4'd7,
    PH_H4     = 4'd8,
    PH_NAMEWS = 4'd9,
    PH_EQ     = 4'd10,
    PH_DQ     = 4'd11,
    PH_SQ     = 4'd12,
    PH_UNQ    = 4'd13
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_END  = 2'd2
  } act_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  // Up to two beats come out of one document byte.
  typedef struct packed {
    logic [1:0] cnt;
    beat_t      b0;
    beat_t      b1;
  } res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_FF);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? (c + CASE_OFS) : c;
  endfunction

  function automatic phase_t skip_next(input logic [7:0] c);
    if (c == CH_GT) return PH_OUT;
    if (is_ws(c)) return PH_GAP;
    return PH_SKIP;
  endfunction

  function automatic phase_t gap_next(input logic [7:0] c);
    if (c == CH_GT) return PH_OUT;
    if (is_ws(c)) return PH_GAP;
    if (fold(c) == CH_H) return PH_H1;
    return PH_SKIP;
  endfunction

endpackage

// ----- rtl/hae_parser.sv -----
module hae_parser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  logic [7:0]    c,
  input  logic          fin,
  output hae_pkg::res_t res
);
  import hae_pkg::*;

  phase_t     phase_r, phase_nxt, nx;
  act_t       act;
  logic [7:0] held_r, held_nxt, hc1;
  logic       hv_r, hv_nxt, hv1;
  logic       a_v, a_l, b_v;

  always_comb begin
    nx = phase_r;
    unique case (phase_r)
      PH_LT:     nx = (fold(c) == CH_A) ? PH_LTA : ((c == CH_LT) ? PH_LT : PH_OUT);
      PH_LTA: begin
        if (is_ws(c)) nx = PH_GAP;
        else if (c == CH_LT) nx = PH_LT;
        else nx = PH_OUT;
      end
      PH_GAP:    nx = gap_next(c);
      PH_SKIP:   nx = skip_next(c);
      PH_H1:     nx = (fold(c) == CH_R) ? PH_H2 : skip_next(c);
      PH_H2:     nx = (fold(c) == CH_E) ? PH_H3 : skip_next(c);
      PH_H3:     nx = (fold(c) == CH_F) ? PH_H4 : skip_next(c);
      PH_H4: begin
        if (c == CH_EQ) nx = PH_EQ;
        else if (is_ws(c)) nx = PH_NAMEWS;
        else nx = skip_next(c);
      end
      PH_NAMEWS: begin
        if (c == CH_EQ) nx = PH_EQ;
        else if (is_ws(c)) nx = PH_NAMEWS;
        else nx = gap_next(c);
      end
      PH_EQ: begin
        if (is_ws(c)) nx = PH_EQ;
        else if (c == CH_DQ) nx = PH_DQ;
        else if (c == CH_SQ) nx = PH_SQ;
        else if (c == CH_GT) nx = PH_OUT;
        else nx = PH_UNQ;
      end
      PH_DQ:     nx = (c == CH_DQ) ? PH_GAP : PH_DQ;
      PH_SQ:     nx = (c == CH_SQ) ? PH_GAP : PH_SQ;
      PH_UNQ: begin
        if (c == CH_GT) nx = PH_OUT;
        else if (is_ws(c)) nx = PH_GAP;
        else nx = PH_UNQ;
      end
      default:   nx = (c == CH_LT) ? PH_LT : PH_OUT;
    endcase
  end

  always_comb begin
    act = ACT_NONE;
    unique case (phase_r)
      PH_EQ: begin
        if (!is_ws(c) && (c != CH_DQ) && (c != CH_SQ) && (c != CH_GT)) act = ACT_ADD;
      end
      PH_DQ:   act = (c == CH_DQ) ? ACT_END : ACT_ADD;
      PH_SQ:   act = (c == CH_SQ) ? ACT_END : ACT_ADD;
      PH_UNQ:  act = ((c == CH_GT) || is_ws(c)) ? ACT_END : ACT_ADD;
      default: act = ACT_NONE;
    endcase
  end

  // The held byte goes out when a newer one replaces it or the value closes;
  // a final byte of the document then flushes whatever is still held.
  always_comb begin
    a_v = 1'b0;
    a_l = 1'b0;
    hv1 = hv_r;
    hc1 = held_r;
    case (act)
      ACT_ADD: begin
        a_v = hv_r;
        hv1 = 1'b1;
        hc1 = c;
      end
      ACT_END: begin
        a_v = hv_r;
        a_l = 1'b1;
        hv1 = 1'b0;
        hc1 = 8'h00;
      end
      default: ;
    endcase
    b_v = fin && hv1;

    res.cnt     = {1'b0, a_v} + {1'b0, b_v};
    res.b1.data = hc1;
    res.b1.last = 1'b1;
    if (a_v) begin
      res.b0.data = held_r;
      res.b0.last = a_l;
    end else begin
      res.b0.data = hc1;
      res.b0.last = 1'b1;
    end

    phase_nxt = fin ? PH_OUT : nx;
    hv_nxt    = fin ? 1'b0 : hv1;
    held_nxt  = fin ? 8'h00 : hc1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OUT;
      hv_r    <= 1'b0;
      held_r  <= 8'h00;
    end else if (fire) begin
      phase_r <= phase_nxt;
      hv_r    <= hv_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ----- rtl/hae_out_fifo.sv -----
module hae_out_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hae_pkg::res_t  res,
  output logic           room2,
  output logic           out_valid,
  input  logic           out_ready,
  output hae_pkg::beat_t out_beat
);
  import hae_pkg::*;

  beat_t      mem_r [4];
  logic [1:0] wr_r, rd_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] n_push;
  logic       pop;

  assign n_push    = push ? res.cnt : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign out_beat  = mem_r[rd_r];
  // Room for a two-beat burst, counted without the beat that may leave now.
  assign room2     = (cnt_r <= 3'd2);
  assign cnt_nxt   = cnt_r + {1'b0, n_push} - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem_r[wr_r] <= res.b0;
    if (n_push == 2'd2) mem_r[wr_r + 2'd1] <= res.b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 2'd0;
      rd_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wr_r  <= wr_r + n_push;
      rd_r  <= rd_r + {1'b0, pop};
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/html_anchor_href_extractor.sv -----
// Anchor href extractor.
// The input channel (in_valid/in_ready) carries one HTML document byte per
// beat in in_byte; in_doc_end marks the final byte of a document. The output
// channel (out_valid/out_ready) carries the bytes of every href value found in
// an anchor tag, one per beat, with out_url_last set on the last byte of each
// value. One byte of each value is held back until the next one arrives, the
// value closes, or the document ends.
// An accepted byte is registered in the input register and parsed from there
// once the output queue has room; its beats are then registered in the queue,
// from which the receiver takes them.
// The block takes one byte per cycle while the output queue has room. A byte
// can release two beats (when it ends the document while a value is open),
// so the four-entry output queue accepts a parse only with room for two;
// in_ready drops only while the queue holds three or more beats that the
// receiver has not taken. While the receiver stalls, beats wait in the queue
// and input continues until that limit. Synchronous reset (rst_n low) returns
// the parser to outside any tag, drops any held byte and empties the queue.
module html_anchor_href_extractor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_doc_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_url_byte,
  output logic       out_url_last
);
  import hae_pkg::*;

  logic       s_vld_r;
  logic [7:0] s_byte_r;
  logic       s_end_r;
  logic       room2, fire;
  res_t       res;
  beat_t      beat;

  assign fire     = s_vld_r && room2;
  assign in_ready = !s_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_ready) begin
      s_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_byte_r <= in_byte;
      s_end_r  <= in_doc_end;
    end
  end

  hae_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .c     (s_byte_r),
    .fin   (s_end_r),
    .res   (res)
  );

  hae_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .res       (res),
    .room2     (room2),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (beat)
  );

  assign out_url_byte = beat.data;
  assign out_url_last = beat.last;

endmodule

// ----- rtl/hae_checker.sv -----
module hae_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_url_byte,
  input logic       out_url_last
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_url_byte) && $stable(out_url_last))
    else $error("result beat changed while stalled");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not empty and ready after reset");

  // A new run of beats follows an accepted byte through the input register and the output queue.
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && $past(rst_n, 2) && $past(rst_n) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without an accepted byte");

  // An empty output queue never holds back the input.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while output queue is empty");

endmodule

bind html_anchor_href_extractor hae_checker u_hae_checker (.*);
